FILE: rtl/core/ordered_list_store_top_defines.svh
// assertion helpers for the ordered list store
`ifndef ORDERED_LIST_STORE_TOP_DEFINES_SVH
`define ORDERED_LIST_STORE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define OLST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define OLST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/olst_pkg.sv
package olst_pkg;

  localparam int ValW  = 32;
  localparam int IdxW  = 5;
  localparam int ModeW = 3;
  localparam int StatW = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_POP    = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_REMOVE = 3'd4,
    MODE_FIND   = 3'd5,
    MODE_READ   = 3'd6,
    MODE_NOP    = 3'd7
  } mode_t;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // what every cell of the row does in a cycle
  typedef enum logic [2:0] {
    ACT_HOLD     = 3'd0,
    ACT_WRITE    = 3'd1,
    ACT_SHIFT_UP = 3'd2,
    ACT_ROT_KEEP = 3'd3,
    ACT_ROT_DROP = 3'd4
  } act_t;

  typedef struct packed {
    act_t                   act;
    logic signed [ValW-1:0] value;
  } cell_ctl_t;

endpackage

FILE: rtl/core/olst_if.sv
interface olst_in_if import olst_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ModeW-1:0]       mode;
  logic [IdxW-1:0]        index;
  logic signed [ValW-1:0] value;

  modport source (output valid, output mode, output index, output value, input ready);
  modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

interface olst_out_if import olst_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] read_value;
  logic signed [IdxW-1:0] found_index;
  logic [StatW-1:0]       status;
  logic [IdxW-1:0]        entry_count;
  logic                   no_entries;

  modport source (output valid, output read_value, output found_index, output status,
                  output entry_count, output no_entries, input ready);
  modport sink   (input valid, input read_value, input found_index, input status,
                  input entry_count, input no_entries, output ready);
endinterface

FILE: rtl/core/ordered_list_store_top.sv
// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells, one entry per
// cell, cell 0 at the front. For push, insert, no-op and every rejected request the result
// is registered at the clock edge that accepts the request, and insert moves all later
// entries up one cell in that same cycle. Pop, delete, remove, find and read rotate the
// stored entries once through cell 0, one entry per cycle; entries to be taken out are
// dropped as they pass the front, which closes the gaps in order. A new request is taken
// only while no rotation is under way and the output register is empty or read in that
// same cycle; a finished rotation holds its result, and the input, for as long as the
// output register stays full. entry_count and found_index carry the low five bits of their
// values; found_index is all ones unless a find succeeded.
`include "ordered_list_store_top_defines.svh"

module ordered_list_store_top import olst_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  olst_in_if.sink    in_req,
  olst_out_if.source out_rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  cell_ctl_t              ctl;
  logic [CW-1:0]          lo;
  logic [CW-1:0]          hi;
  logic                   busy;
  logic signed [ValW-1:0] cell_data [DEPTH];
  logic                   rotating;
  logic                   find_taken;
  logic                   empty_rsp;
  logic                   empty_clean;
  logic                   found_rsp;

  olst_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .head_data (cell_data[0]),
    .ctl       (ctl),
    .lo        (lo),
    .hi        (hi),
    .busy      (busy)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ValW-1:0] prev_d;
    logic signed [ValW-1:0] next_d;

    if (g == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_prev
      assign prev_d = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_d = cell_data[0];
    end else begin : g_next
      assign next_d = cell_data[g+1];
    end

    olst_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .lo        (lo),
      .hi        (hi),
      .prev_data (prev_d),
      .next_data (next_d),
      .head_data (cell_data[0]),
      .data      (cell_data[g])
    );
  end

  assign rotating    = (ctl.act == ACT_ROT_KEEP) || (ctl.act == ACT_ROT_DROP);
  assign find_taken  = in_req.valid && in_req.ready && (in_req.mode == MODE_FIND);
  assign empty_rsp   = out_rsp.valid && (out_rsp.status == ST_EMPTY);
  assign empty_clean = out_rsp.no_entries && (out_rsp.read_value == '0);
  assign found_rsp   = out_rsp.valid && (out_rsp.found_index != -1);

  `OLST_ASSERT_NOW(a_rotate_only_busy, rotating, busy, "rotation outside a scan")
  `OLST_ASSERT_NOW(a_no_accept_busy, busy, !in_req.ready, "request taken during a scan")
  `OLST_ASSERT_NEXT(a_find_scans, find_taken, busy, "find did not start a scan")
  `OLST_ASSERT_NOW(a_empty_result, empty_rsp, empty_clean, "empty status with data")
  `OLST_ASSERT_NOW(a_found_ok, found_rsp, out_rsp.status == ST_OK, "index found without ok status")

endmodule

FILE: rtl/core/olst_cell.sv
module olst_cell import olst_pkg::*; #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [CW-1:0]          lo,
  input  logic [CW-1:0]          hi,
  input  logic signed [ValW-1:0] prev_data,
  input  logic signed [ValW-1:0] next_data,
  input  logic signed [ValW-1:0] head_data,
  output logic signed [ValW-1:0] data
);

  localparam logic [CW:0] Pos     = (CW+1)'(IDX);
  localparam logic [CW:0] PosNext = (CW+1)'(IDX + 1);

  logic signed [ValW-1:0] data_r;
  logic signed [ValW-1:0] data_nxt;
  logic [CW:0]            lo_x;
  logic [CW:0]            hi_x;

  assign lo_x = {1'b0, lo};
  assign hi_x = {1'b0, hi};

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.act)
      ACT_HOLD: ;
      ACT_WRITE: begin
        if (Pos == lo_x) data_nxt = ctl.value;
      end
      ACT_SHIFT_UP: begin
        if (Pos == lo_x) data_nxt = ctl.value;
        else if (Pos > lo_x && Pos <= hi_x) data_nxt = prev_data;
      end
      ACT_ROT_KEEP: begin
        if (PosNext < hi_x) data_nxt = next_data;
        else if (PosNext == hi_x) data_nxt = head_data;
      end
      ACT_ROT_DROP: begin
        if (PosNext < hi_x) data_nxt = next_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

FILE: rtl/core/olst_ctrl.sv
module olst_ctrl import olst_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  olst_in_if.sink                in_req,
  olst_out_if.source             out_rsp,
  input  logic signed [ValW-1:0] head_data,
  output cell_ctl_t              ctl,
  output logic [CW-1:0]          lo,
  output logic [CW-1:0]          hi,
  output logic                   busy
);

  localparam int CMPW = (CW > IdxW) ? CW : IdxW;
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          n_r, n_nxt;
  logic [CW-1:0]          step_r, step_nxt;
  logic [CW-1:0]          tgt_r, tgt_nxt;
  mode_t                  mode_r, mode_nxt;
  logic signed [ValW-1:0] val_r, val_nxt;
  logic signed [ValW-1:0] rd_r, rd_nxt;
  logic                   found_r, found_nxt;
  logic [IdxW-1:0]        fidx_r, fidx_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic signed [ValW-1:0] out_rd_r, out_rd_nxt;
  logic [IdxW-1:0]        out_fidx_r, out_fidx_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [IdxW-1:0]        out_cnt_r, out_cnt_nxt;
  logic                   out_empty_r, out_empty_nxt;

  logic                   out_free;
  logic                   accept;
  logic [CMPW-1:0]        cnt_x;
  logic [CMPW-1:0]        idx_x;
  mode_t                  in_mode;
  status_t                st;
  logic                   start;
  logic                   hit;
  logic                   drop;

  function automatic logic [IdxW-1:0] low5(input logic [CW-1:0] v);
    logic [CMPW-1:0] w;
    w = CMPW'(v);
    return w[IdxW-1:0];
  endfunction

  assign out_free     = !out_valid_r || out_rsp.ready;
  assign in_req.ready = (state_r == S_IDLE) && out_free;
  assign accept       = in_req.valid && in_req.ready;
  assign cnt_x        = CMPW'(count_r);
  assign idx_x        = CMPW'(in_req.index);
  assign in_mode      = mode_t'(in_req.mode);
  assign hit          = (head_data == val_r);
  assign busy         = (state_r == S_SCAN);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    n_nxt          = n_r;
    step_nxt       = step_r;
    tgt_nxt        = tgt_r;
    mode_nxt       = mode_r;
    val_nxt        = val_r;
    rd_nxt         = rd_r;
    found_nxt      = found_r;
    fidx_nxt       = fidx_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_rd_nxt     = out_rd_r;
    out_fidx_nxt   = out_fidx_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    out_empty_nxt  = out_empty_r;
    ctl.act        = ACT_HOLD;
    ctl.value      = in_req.value;
    lo             = count_r;
    hi             = count_r;
    st             = ST_OK;
    start          = 1'b0;
    drop           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_PUSH: begin
              if (count_r == Full) st = ST_FULL;
              else begin
                ctl.act   = ACT_WRITE;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            MODE_INSERT: begin
              if (count_r == Full) st = ST_FULL;
              else if (idx_x > cnt_x) st = ST_RANGE;
              else begin
                ctl.act   = ACT_SHIFT_UP;
                lo        = idx_x[CW-1:0];
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            MODE_POP, MODE_DELETE, MODE_READ: begin
              if (count_r == '0) st = ST_EMPTY;
              else if (in_mode != MODE_POP && idx_x >= cnt_x) st = ST_RANGE;
              else begin
                start   = 1'b1;
                tgt_nxt = (in_mode == MODE_POP) ? CW'(count_r - 1'b1) : idx_x[CW-1:0];
              end
            end
            MODE_REMOVE, MODE_FIND: start = 1'b1;
            MODE_NOP: ;
            default: ;
          endcase
          if (start) begin
            state_nxt = S_SCAN;
            n_nxt     = count_r;
            step_nxt  = '0;
            found_nxt = 1'b0;
            fidx_nxt  = '1;
            rd_nxt    = '0;
            mode_nxt  = in_mode;
            val_nxt   = in_req.value;
          end else begin
            out_valid_nxt  = 1'b1;
            out_rd_nxt     = '0;
            out_fidx_nxt   = '1;
            out_status_nxt = st;
            out_cnt_nxt    = low5(count_nxt);
            out_empty_nxt  = (count_nxt == '0);
          end
        end
      end
      S_SCAN: begin
        if (step_r != n_r) begin
          // head of the row leaves cell 0 and is kept at the tail or dropped
          drop = ((mode_r == MODE_POP || mode_r == MODE_DELETE) && step_r == tgt_r) ||
                 (mode_r == MODE_REMOVE && hit);
          ctl.act = drop ? ACT_ROT_DROP : ACT_ROT_KEEP;
          if (drop) count_nxt = CW'(count_r - 1'b1);
          if ((mode_r == MODE_POP || mode_r == MODE_READ) && step_r == tgt_r) begin
            rd_nxt = head_data;
          end
          if (mode_r == MODE_FIND && !found_r && hit) begin
            found_nxt = 1'b1;
            fidx_nxt  = low5(step_r);
          end
          step_nxt = CW'(step_r + 1'b1);
        end else if (out_free) begin
          priority if (mode_r == MODE_REMOVE) st = (count_r == n_r) ? ST_NOTFOUND : ST_OK;
          else if (mode_r == MODE_FIND) st = found_r ? ST_OK : ST_NOTFOUND;
          else st = ST_OK;
          out_valid_nxt  = 1'b1;
          out_rd_nxt     = rd_r;
          out_fidx_nxt   = fidx_r;
          out_status_nxt = st;
          out_cnt_nxt    = low5(count_r);
          out_empty_nxt  = (count_r == '0);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    step_r       <= step_nxt;
    tgt_r        <= tgt_nxt;
    mode_r       <= mode_nxt;
    val_r        <= val_nxt;
    rd_r         <= rd_nxt;
    found_r      <= found_nxt;
    fidx_r       <= fidx_nxt;
    out_rd_r     <= out_rd_nxt;
    out_fidx_r   <= out_fidx_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.read_value  = out_rd_r;
  assign out_rsp.found_index = $signed(out_fidx_r);
  assign out_rsp.status      = out_status_r;
  assign out_rsp.entry_count = out_cnt_r;
  assign out_rsp.no_entries  = out_empty_r;

endmodule
